/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked at every clock edge outside reset.
`define BPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`else

`define BPS_ASSERT(lbl, prop, msg)
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/bps_pkg.sv */
// Shared constants, codes and types of the bilinear pixel sampler.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int CH_MAX     = 255;
  localparam int COORD_W    = 17;
  localparam int POS_W      = 8;
  localparam int REG_W      = 9;

  // Pixel store is split in four banks by row and column parity.
  localparam int NUM_BANKS  = 4;
  localparam int BANK_IDX_W = 2;

  // Depth of the queue between front and back.
  localparam int Q_DEPTH    = 4;

  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(256);
  localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(256);

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/bilinear_pixel_sampler_top.sv */
// Top level of the bilinear pixel sampler: register port, front, queue and back.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one transaction per item. mode_i
//    low stores the pixel red/green/blue_in_i at (write_col_i, write_row_i);
//    mode_i high samples at (sample_col_i, sample_row_i), signed fixed point
//    with FRAC_BITS fraction bits. Writes produce no result.
//  - Output channel (out_valid_o / out_stall_i): one transaction per sample
//    carrying the rounded red/green/blue_out_o, in input order.
//  - APB port: image_width at 0x0, image_height at 0x4 (9 bits each). They
//    must be written only while the block is idle; the block does not enforce this.
//  - Throughput: one item per cycle while in_stall_o is low. The store is four banks
//    split by row and column parity, so the four neighbors come out of one read per bank.
//  - Path: an accepted sample passes the queue head, then the registered bank
//    read, X blend and Y blend stages before it shows on the output.
//  - Stall: a stalled result freezes the back pipeline; the 4-entry command
//    queue keeps taking items, then raises in_stall_o when full.
//  - Reset: queue and pipeline empty, sizes back to 256x256. The pixel store
//    is not cleared; a pixel must be written before it is sampled.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bilinear_pixel_sampler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [bps_pkg::APB_AW-1:0]    paddr,
  input  logic        [bps_pkg::APB_DW-1:0]    pwdata,
  output logic        [bps_pkg::APB_DW-1:0]    prdata,
  output logic                                 pready,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 mode_i,
  input  logic        [bps_pkg::POS_W-1:0]     write_col_i,
  input  logic        [bps_pkg::POS_W-1:0]     write_row_i,
  input  logic        [bps_pkg::CH_W-1:0]      red_in_i,
  input  logic        [bps_pkg::CH_W-1:0]      green_in_i,
  input  logic        [bps_pkg::CH_W-1:0]      blue_in_i,
  input  logic signed [bps_pkg::COORD_W-1:0]   sample_col_i,
  input  logic signed [bps_pkg::COORD_W-1:0]   sample_row_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [bps_pkg::CH_W-1:0]      red_out_o,
  output logic        [bps_pkg::CH_W-1:0]      green_out_o,
  output logic        [bps_pkg::CH_W-1:0]      blue_out_o
);
  import bps_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int BCW = (CW > 1) ? CW - 1 : 1;
  localparam int BRW = (RW > 1) ? RW - 1 : 1;
  localparam int BAW = BCW + BRW;

  // Command handed from front to back through the queue.
  typedef struct packed {
    logic                            is_write;
    logic [BANK_IDX_W-1:0]           wr_bank;
    logic [BAW-1:0]                  wr_addr;
    logic [PIX_W-1:0]                pixel;
    logic [NUM_BANKS-1:0][BAW-1:0]   rd_addr;
    logic [FRAC_BITS-1:0]            dx;
    logic [FRAC_BITS-1:0]            dy;
    logic                            x1_ok;
    logic                            y1_ok;
    logic                            x0_odd;
    logic                            y0_odd;
  } cmd_t;

  // ---------------- configuration registers ----------------
  logic             cfg_wr;
  reg_idx_e         cfg_idx;
  logic [REG_W-1:0] width_q, width_d;
  logic [REG_W-1:0] height_q, height_d;
  cfg_t             cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_d  = pwdata[REG_W-1:0];
        REG_IMAGE_HEIGHT: height_d = pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(height_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg.width  = width_q;
  assign cfg.height = height_q;

  // ---------------- front, queue, back ----------------
  logic q_full, q_push, q_valid, q_pop;
  cmd_t front_cmd, q_cmd;

  bps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .cmd_t      (cmd_t)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .cfg_i        (cfg),
    .mode_i       (mode_i),
    .write_col_i  (write_col_i),
    .write_row_i  (write_row_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .sample_col_i (sample_col_i),
    .sample_row_i (sample_row_i),
    .cmd_o        (front_cmd)
  );

  bps_fifo #(
    .cmd_t (cmd_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  bps_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .cmd_t      (cmd_t)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  // ---------------- assertions ----------------
  // A held result must freeze the back end, so nothing leaves the queue.
  `BPS_ASSERT(a_hold_blocks_pop, (out_valid_o && out_stall_i) |-> !q_pop, "queue popped while result held")
  // A push leaves the queue non-empty in the next cycle.
  `BPS_ASSERT_NEXT(a_push_visible, q_push, q_valid, "pushed command missing from queue")
  // A full queue can never look empty to the back end.
  `BPS_ASSERT(a_full_has_entry, q_full |-> q_valid, "queue full but reported empty")

endmodule

`default_nettype wire

/* rtl/bps_front.sv */
// Front end: input handshake, coordinate clamp and bank address generation.
`timescale 1ns / 1ps
`default_nettype none

module bps_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8,
  parameter type cmd_t     = logic
) (
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  input  bps_pkg::cfg_t                        cfg_i,
  input  logic                                 mode_i,
  input  logic        [bps_pkg::POS_W-1:0]     write_col_i,
  input  logic        [bps_pkg::POS_W-1:0]     write_row_i,
  input  logic        [bps_pkg::CH_W-1:0]      red_in_i,
  input  logic        [bps_pkg::CH_W-1:0]      green_in_i,
  input  logic        [bps_pkg::CH_W-1:0]      blue_in_i,
  input  logic signed [bps_pkg::COORD_W-1:0]   sample_col_i,
  input  logic signed [bps_pkg::COORD_W-1:0]   sample_row_i,
  output cmd_t                                 cmd_o
);
  import bps_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int BCW  = (CW > 1) ? CW - 1 : 1;
  localparam int BRW  = (RW > 1) ? RW - 1 : 1;
  localparam int SWW  = CW + 1;
  localparam int SWH  = RW + 1;
  localparam int XW   = CW + FRAC_BITS;
  localparam int YW   = RW + FRAC_BITS;
  localparam int XCW  = ((XW > COORD_W) ? XW : COORD_W) + 2;
  localparam int YCW  = ((YW > COORD_W) ? YW : COORD_W) + 2;

  logic [SWW-1:0]        width_eff;
  logic [SWH-1:0]        height_eff;
  logic [CW-1:0]         w_m1;
  logic [RW-1:0]         h_m1;
  logic signed [XCW-1:0] xv, xtop;
  logic signed [YCW-1:0] yv, ytop;
  logic [XW-1:0]         xs;
  logic [YW-1:0]         ys;
  logic [CW-1:0]         x0, wcol;
  logic [RW-1:0]         y0, wrow;
  logic                  is_write, wr_in_store;

  // Size registers: zero acts as one, anything above the store acts as the store size.
  always_comb begin
    if (cfg_i.width == '0) begin
      width_eff = SWW'(1);
    end else if (32'(cfg_i.width) > 32'(MAX_WIDTH)) begin
      width_eff = SWW'(MAX_WIDTH);
    end else begin
      width_eff = SWW'(cfg_i.width);
    end
    if (cfg_i.height == '0) begin
      height_eff = SWH'(1);
    end else if (32'(cfg_i.height) > 32'(MAX_HEIGHT)) begin
      height_eff = SWH'(MAX_HEIGHT);
    end else begin
      height_eff = SWH'(cfg_i.height);
    end
  end

  assign w_m1 = CW'(width_eff - SWW'(1));
  assign h_m1 = RW'(height_eff - SWH'(1));
  assign xtop = XCW'({w_m1, {FRAC_BITS{1'b0}}});
  assign ytop = YCW'({h_m1, {FRAC_BITS{1'b0}}});
  assign xv   = XCW'(sample_col_i);
  assign yv   = YCW'(sample_row_i);

  // Clamp to 0 .. (size-1) in fixed point.
  always_comb begin
    if (xv[XCW-1]) begin
      xs = '0;
    end else if (xv >= xtop) begin
      xs = XW'(xtop);
    end else begin
      xs = XW'(xv);
    end
    if (yv[YCW-1]) begin
      ys = '0;
    end else if (yv >= ytop) begin
      ys = YW'(ytop);
    end else begin
      ys = YW'(yv);
    end
  end

  assign x0   = xs[XW-1:FRAC_BITS];
  assign y0   = ys[YW-1:FRAC_BITS];
  assign wcol = CW'(write_col_i);
  assign wrow = RW'(write_row_i);

  assign is_write    = (mode_i == MODE_WRITE);
  assign wr_in_store = (32'(write_col_i) < 32'(MAX_WIDTH)) &&
                       (32'(write_row_i) < 32'(MAX_HEIGHT));

  // Writes outside the store are dropped here and never enter the queue.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && (!is_write || wr_in_store);

  always_comb begin : p_cmd
    logic [BANK_IDX_W-1:0] bidx;
    logic [BCW-1:0]        x0h, col_half;
    logic [BRW-1:0]        y0h, row_half;
    x0h = BCW'(x0 >> 1);
    y0h = BRW'(y0 >> 1);
    cmd_o          = '0;
    cmd_o.is_write = is_write;
    cmd_o.wr_bank  = {wrow[0], wcol[0]};
    cmd_o.wr_addr  = {BRW'(wrow >> 1), BCW'(wcol >> 1)};
    cmd_o.pixel    = {red_in_i, green_in_i, blue_in_i};
    cmd_o.dx       = xs[FRAC_BITS-1:0];
    cmd_o.dy       = ys[FRAC_BITS-1:0];
    cmd_o.x0_odd   = x0[0];
    cmd_o.y0_odd   = y0[0];
    cmd_o.x1_ok    = (SWW'(x0) + SWW'(1)) < width_eff;
    cmd_o.y1_ok    = (SWH'(y0) + SWH'(1)) < height_eff;
    // Each bank holds exactly one of the four neighbors; an odd base bumps the
    // even-parity bank to the next half index.
    for (int b = 0; b < NUM_BANKS; b++) begin
      bidx     = BANK_IDX_W'(b);
      col_half = x0h + BCW'(x0[0] & ~bidx[0]);
      row_half = y0h + BRW'(y0[0] & ~bidx[1]);
      cmd_o.rd_addr[b] = {row_half, col_half};
    end
  end

endmodule

`default_nettype wire

/* rtl/bps_fifo.sv */
// Small command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module bps_fifo #(
  parameter type cmd_t = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);
  import bps_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t          entry_q [Q_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PW + 1)'(push_i) - (PW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (cnt_q == (PW + 1)'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

/* rtl/bps_back.sv */
// Back end: banked pixel store, X blend, Y blend with rounding, output register.
`timescale 1ns / 1ps
`default_nettype none

module bps_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8,
  parameter type cmd_t     = logic
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  cmd_t                        cmd_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bps_pkg::CH_W-1:0]    red_out_o,
  output logic [bps_pkg::CH_W-1:0]    green_out_o,
  output logic [bps_pkg::CH_W-1:0]    blue_out_o
);
  import bps_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int BCW        = (CW > 1) ? CW - 1 : 1;
  localparam int BRW        = (RW > 1) ? RW - 1 : 1;
  localparam int BAW        = BCW + BRW;
  localparam int BANK_DEPTH = 1 << BAW;
  localparam int C0W        = CH_W + FRAC_BITS;          // X blend, scale S
  localparam int XPW        = C0W + 2;
  localparam int YPW        = C0W + FRAC_BITS + 2;       // Y blend, scale S^2
  localparam int RND_SH     = 2 * FRAC_BITS;

  logic adv, take;

  // Whole pipeline freezes only while a finished result is held back.
  assign adv     = !(out_valid_o && out_stall_i);
  assign take    = q_valid_i && adv;
  assign q_pop_o = take;

  // ---------------- stage 1: bank access ----------------
  logic [PIX_W-1:0] rd_data [NUM_BANKS];

  for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
    logic [PIX_W-1:0] mem [BANK_DEPTH];
    logic [PIX_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (take && cmd_i.is_write && (cmd_i.wr_bank == BANK_IDX_W'(gb))) begin
        mem[cmd_i.wr_addr] <= cmd_i.pixel;
      end
      if (adv) begin
        rd_q <= mem[cmd_i.rd_addr[gb]];
      end
    end
    assign rd_data[gb] = rd_q;
  end

  logic                 s1_valid_q;
  logic [FRAC_BITS-1:0] s1_dx_q, s1_dy_q;
  logic                 s1_x1_ok_q, s1_y1_ok_q, s1_x0_odd_q, s1_y0_odd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= take && !cmd_i.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dx_q     <= cmd_i.dx;
      s1_dy_q     <= cmd_i.dy;
      s1_x1_ok_q  <= cmd_i.x1_ok;
      s1_y1_ok_q  <= cmd_i.y1_ok;
      s1_x0_odd_q <= cmd_i.x0_odd;
      s1_y0_odd_q <= cmd_i.y0_odd;
    end
  end

  // ---------------- stage 2: neighbor routing and X blend ----------------
  logic [PIX_W-1:0] p00, p10, p01, p11;
  logic [C0W-1:0]   c0_d [NUM_CH];
  logic [C0W-1:0]   c1_d [NUM_CH];

  always_comb begin
    // Far neighbors outside the image read as black.
    p00 = rd_data[{s1_y0_odd_q, s1_x0_odd_q}];
    p10 = s1_x1_ok_q ? rd_data[{s1_y0_odd_q, !s1_x0_odd_q}] : '0;
    p01 = s1_y1_ok_q ? rd_data[{!s1_y0_odd_q, s1_x0_odd_q}] : '0;
    p11 = (s1_x1_ok_q && s1_y1_ok_q) ? rd_data[{!s1_y0_odd_q, !s1_x0_odd_q}] : '0;
  end

  always_comb begin : p_xblend
    logic [CH_W-1:0]         a, b, c, d;
    logic signed [CH_W:0]    dab, dcd;
    logic signed [FRAC_BITS:0] dxs;
    logic signed [XPW-1:0]   pa, pc, c0f, c1f;
    dxs = $signed({1'b0, s1_dx_q});
    for (int ch = 0; ch < NUM_CH; ch++) begin
      a   = p00[ch*CH_W +: CH_W];
      b   = p10[ch*CH_W +: CH_W];
      c   = p01[ch*CH_W +: CH_W];
      d   = p11[ch*CH_W +: CH_W];
      dab = $signed({1'b0, b}) - $signed({1'b0, a});
      dcd = $signed({1'b0, d}) - $signed({1'b0, c});
      pa  = dxs * dab;
      pc  = dxs * dcd;
      c0f = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + pa;
      c1f = $signed({2'b00, c, {FRAC_BITS{1'b0}}}) + pc;
      c0_d[ch] = c0f[C0W-1:0];
      c1_d[ch] = c1f[C0W-1:0];
    end
  end

  logic                 s2_valid_q;
  logic [FRAC_BITS-1:0] s2_dy_q;
  logic [C0W-1:0]       c0_q [NUM_CH];
  logic [C0W-1:0]       c1_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_dy_q <= s1_dy_q;
      c0_q    <= c0_d;
      c1_q    <= c1_d;
    end
  end

  // ---------------- stage 3: Y blend, round, clamp ----------------
  logic [CH_W-1:0] res_d [NUM_CH];

  always_comb begin : p_yblend
    logic signed [C0W:0]       dc;
    logic signed [FRAC_BITS:0] dys;
    logic signed [YPW-1:0]     py, v, r;
    dys = $signed({1'b0, s2_dy_q});
    for (int ch = 0; ch < NUM_CH; ch++) begin
      dc = $signed({1'b0, c1_q[ch]}) - $signed({1'b0, c0_q[ch]});
      py = dys * dc;
      v  = $signed({2'b00, c0_q[ch], {FRAC_BITS{1'b0}}}) + py;
      r  = (v + (YPW'(1) <<< (RND_SH - 1))) >>> RND_SH;   // half rounds up
      if (r[YPW-1]) begin
        res_d[ch] = '0;
      end else if (r > YPW'(CH_MAX)) begin
        res_d[ch] = CH_W'(CH_MAX);
      end else begin
        res_d[ch] = CH_W'(r);
      end
    end
  end

  logic            out_valid_q;
  logic [CH_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      red_q   <= res_d[2];
      green_q <= res_d[1];
      blue_q  <= res_d[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

endmodule

`default_nettype wire
